/* rtl/ddcf_pkg.sv */
// Shared types and constants for the dual-delay comb filter.
// Used by ddcf_ctrl, ddcf_datapath and dual_delay_comb_filter; no dependencies.
package ddcf_pkg;

   // Fixed field widths of the item and register interfaces
   localparam int DELAY_BITS = 24;
   localparam int GAIN_BITS  = 16;
   localparam int CFG_BITS   = 16;
   localparam int GAIN_FRAC  = 12;

   localparam logic [CFG_BITS-1:0] MAX_DELAY_RESET = 16'd48000;

   // Multiplier operand select
   typedef logic [2:0] mac_src_type;

   localparam mac_src_type MAC_INTERP_I = 3'd0;
   localparam mac_src_type MAC_INTERP_J = 3'd1;
   localparam mac_src_type MAC_GAIN_X   = 3'd2;
   localparam mac_src_type MAC_GAIN_DX  = 3'd3;
   localparam mac_src_type MAC_GAIN_DY  = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic        load_item;   // capture item, write sample into input ring
      logic        tap_sel;     // 0: feedforward / input ring, 1: feedback / output ring
      logic        clamp_load;  // register clamped delay of selected tap
      logic        addr_load;   // register ring indexes and fraction
      logic        rd_en;       // issue ring read
      logic        rd_j;        // read upper neighbor instead of lower
      logic        mac_en;      // multiplier issue
      logic        mac_clr;     // first term of a sum
      mac_src_type mac_src;
      logic        save_en;     // store interpolated tap value
      logic        out_load;    // load result, write output ring, advance position
   } ddcf_cmd_type;

endpackage

/* rtl/ddcf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both history rings.
module ddcf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/ddcf_ctrl.sv */
// Sequencer for the dual-delay comb filter: steps one item through the datapath.
// Depends on ddcf_pkg.
module ddcf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ddcf_pkg::ddcf_cmd_type cmd
);
   import ddcf_pkg::*;

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_FF_CLAMP  = 5'd1;
   localparam logic [4:0] ST_FF_ADDR   = 5'd2;
   localparam logic [4:0] ST_FF_RD_I   = 5'd3;
   localparam logic [4:0] ST_FF_RD_J   = 5'd4;
   localparam logic [4:0] ST_FF_MAC_J  = 5'd5;
   localparam logic [4:0] ST_FF_SETTLE = 5'd6;
   localparam logic [4:0] ST_FF_SAVE   = 5'd7;
   localparam logic [4:0] ST_FB_CLAMP  = 5'd8;
   localparam logic [4:0] ST_FB_ADDR   = 5'd9;
   localparam logic [4:0] ST_FB_RD_I   = 5'd10;
   localparam logic [4:0] ST_FB_RD_J   = 5'd11;
   localparam logic [4:0] ST_FB_MAC_J  = 5'd12;
   localparam logic [4:0] ST_FB_SETTLE = 5'd13;
   localparam logic [4:0] ST_FB_SAVE   = 5'd14;
   localparam logic [4:0] ST_G_X       = 5'd15;
   localparam logic [4:0] ST_G_DX      = 5'd16;
   localparam logic [4:0] ST_G_DY      = 5'd17;
   localparam logic [4:0] ST_G_SETTLE  = 5'd18;
   localparam logic [4:0] ST_FINISH    = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // output slot frees in the same cycle its transfer completes
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_FF_CLAMP;
            end
         end
         ST_FF_CLAMP: begin
            cmd.clamp_load = 1'b1;
            state_in       = ST_FF_ADDR;
         end
         ST_FF_ADDR: begin
            cmd.addr_load = 1'b1;
            state_in      = ST_FF_RD_I;
         end
         ST_FF_RD_I: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_FF_RD_J;
         end
         ST_FF_RD_J: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_j    = 1'b1;
            cmd.mac_en  = 1'b1;
            cmd.mac_clr = 1'b1;
            cmd.mac_src = MAC_INTERP_I;
            state_in    = ST_FF_MAC_J;
         end
         ST_FF_MAC_J: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_src = MAC_INTERP_J;
            state_in    = ST_FF_SETTLE;
         end
         ST_FF_SETTLE: begin
            state_in = ST_FF_SAVE;
         end
         ST_FF_SAVE: begin
            cmd.save_en = 1'b1;
            state_in    = ST_FB_CLAMP;
         end
         ST_FB_CLAMP: begin
            cmd.tap_sel    = 1'b1;
            cmd.clamp_load = 1'b1;
            state_in       = ST_FB_ADDR;
         end
         ST_FB_ADDR: begin
            cmd.tap_sel   = 1'b1;
            cmd.addr_load = 1'b1;
            state_in      = ST_FB_RD_I;
         end
         ST_FB_RD_I: begin
            cmd.tap_sel = 1'b1;
            cmd.rd_en   = 1'b1;
            state_in    = ST_FB_RD_J;
         end
         ST_FB_RD_J: begin
            cmd.tap_sel = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_j    = 1'b1;
            cmd.mac_en  = 1'b1;
            cmd.mac_clr = 1'b1;
            cmd.mac_src = MAC_INTERP_I;
            state_in    = ST_FB_MAC_J;
         end
         ST_FB_MAC_J: begin
            cmd.tap_sel = 1'b1;
            cmd.mac_en  = 1'b1;
            cmd.mac_src = MAC_INTERP_J;
            state_in    = ST_FB_SETTLE;
         end
         ST_FB_SETTLE: begin
            cmd.tap_sel = 1'b1;
            state_in    = ST_FB_SAVE;
         end
         ST_FB_SAVE: begin
            cmd.tap_sel = 1'b1;
            cmd.save_en = 1'b1;
            state_in    = ST_G_X;
         end
         ST_G_X: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_clr = 1'b1;
            cmd.mac_src = MAC_GAIN_X;
            state_in    = ST_G_DX;
         end
         ST_G_DX: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_src = MAC_GAIN_DX;
            state_in    = ST_G_DY;
         end
         ST_G_DY: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_src = MAC_GAIN_DY;
            state_in    = ST_G_SETTLE;
         end
         ST_G_SETTLE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/ddcf_datapath.sv */
// Datapath of the dual-delay comb filter: history rings, tap addressing,
// shared multiply-accumulate, saturation and result register.
// Depends on ddcf_pkg and ddcf_ram.
module ddcf_datapath #(
   parameter int RING_DEPTH      = 65536,
   parameter int SAMPLE_BITS     = 24,
   parameter int DELAY_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ddcf_pkg::ddcf_cmd_type                cmd,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  logic [ddcf_pkg::DELAY_BITS-1:0]       req_ff_delay,
   input  logic [ddcf_pkg::DELAY_BITS-1:0]       req_fb_delay,
   input  logic signed [ddcf_pkg::GAIN_BITS-1:0] req_direct_gain,
   input  logic signed [ddcf_pkg::GAIN_BITS-1:0] req_ff_gain,
   input  logic signed [ddcf_pkg::GAIN_BITS-1:0] req_fb_gain,
   input  logic                                  csr_write,
   input  logic [ddcf_pkg::CFG_BITS-1:0]         csr_max_delay,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out
);
   import ddcf_pkg::*;

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int F   = DELAY_FRAC_BITS;
   localparam int CW  = ((AW + F) > DELAY_BITS ? (AW + F) : DELAY_BITS) + 2;
   localparam int MB  = ((F + 2) > GAIN_BITS) ? (F + 2) : GAIN_BITS;
   localparam int PRW = SAMPLE_BITS + MB;
   localparam int ACW = PRW + 2;

   localparam logic [CW-1:0] ONE_FX    = CW'(1) << F;
   localparam logic [CW-1:0] TOTAL_FX  = CW'(RING_DEPTH) << F;
   localparam logic [CW-1:0] DEPTH_MAX = CW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] FRAC_MASK = ONE_FX - CW'(1);
   localparam logic [AW-1:0] LAST_IDX  = AW'(RING_DEPTH - 1);

   localparam logic signed [ACW-1:0] SAT_HI = (ACW'(1) << (SAMPLE_BITS - 1)) - ACW'(1);
   localparam logic signed [ACW-1:0] SAT_LO = ~SAT_HI;

   // item registers
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [DELAY_BITS-1:0]         ffd_ff, fbd_ff;
   logic signed [GAIN_BITS-1:0]   ga_ff, gb_ff, gc_ff;

   logic [CFG_BITS-1:0] max_delay_ff;
   logic [CW-1:0]       lim_ff, lim_in, lim_whole, md_ext;
   logic [CW-1:0]       dly_ff, dly_in, dsel;
   logic [CW-1:0]       pos_raw, pos;
   logic [AW-1:0]       i_ff, j_ff, idx, idx_nxt;
   logic [F:0]          frac_ff, wt_i;

   logic [AW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;

   logic [AW-1:0]          rd_addr;
   logic                   rd_live_ff, rd_tap_ff;
   logic                   in_live, out_live;
   logic [SAMPLE_BITS-1:0] in_rd_data, out_rd_data;
   logic signed [SAMPLE_BITS-1:0] tap_data;

   logic signed [SAMPLE_BITS-1:0] op_a;
   logic signed [MB-1:0]          op_b;
   logic signed [PRW-1:0]         prod_in, prod_ff;
   logic                          mac_en_ff, mac_clr_ff;
   logic signed [ACW-1:0]         acc_ff, q;
   logic signed [SAMPLE_BITS-1:0] dx_ff, dy_ff, interp, y_sat;
   logic signed [SAMPLE_BITS-1:0] rsp_ff;

   // ---- delay bound from the register ----
   assign md_ext = CW'(max_delay_ff);

   always_comb begin
      priority if (md_ext > DEPTH_MAX) begin
         lim_whole = DEPTH_MAX;
      end else if (md_ext == '0) begin
         lim_whole = CW'(1);
      end else begin
         lim_whole = md_ext;
      end
      lim_in = lim_whole << F;
   end

   // ---- clamp of the selected tap ----
   assign dsel = cmd.tap_sel ? CW'(fbd_ff) : CW'(ffd_ff);

   always_comb begin
      priority if (dsel > lim_ff) begin
         dly_in = lim_ff;
      end else if (dsel < ONE_FX) begin
         dly_in = ONE_FX;
      end else begin
         dly_in = dsel;
      end
   end

   // ---- read point: one compare-subtract wrap ----
   assign pos_raw = (CW'(wp_ff) << F) + TOTAL_FX - dly_ff;
   assign pos     = (pos_raw >= TOTAL_FX) ? (pos_raw - TOTAL_FX) : pos_raw;
   assign idx     = AW'(pos >> F);
   assign idx_nxt = (idx == LAST_IDX) ? '0 : (idx + AW'(1));

   // ---- ring reads, unwritten entries read as zero ----
   assign rd_addr  = cmd.rd_j ? j_ff : i_ff;
   assign in_live  = wrapped_ff || (rd_addr <= wp_ff);
   assign out_live = wrapped_ff || (rd_addr < wp_ff);
   assign tap_data = rd_live_ff ? (rd_tap_ff ? out_rd_data : in_rd_data) : '0;

   ddcf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_in_ring (
      .clock   (clock),
      .wr_en   (cmd.load_item),
      .wr_addr (wp_ff),
      .wr_data (req_sample_in),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (in_rd_data)
   );

   ddcf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_out_ring (
      .clock   (clock),
      .wr_en   (cmd.out_load),
      .wr_addr (wp_ff),
      .wr_data (y_sat),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (out_rd_data)
   );

   // ---- shared multiplier ----
   assign wt_i = (F + 1)'(ONE_FX) - frac_ff;

   always_comb begin
      unique case (cmd.mac_src)
         MAC_INTERP_I: begin
            op_a = tap_data;
            op_b = MB'({1'b0, wt_i});
         end
         MAC_INTERP_J: begin
            op_a = tap_data;
            op_b = MB'({1'b0, frac_ff});
         end
         MAC_GAIN_X: begin
            op_a = x_ff;
            op_b = MB'(ga_ff);
         end
         MAC_GAIN_DX: begin
            op_a = dx_ff;
            op_b = MB'(gb_ff);
         end
         MAC_GAIN_DY: begin
            op_a = dy_ff;
            op_b = MB'(gc_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   // arithmetic shifts give floor division
   assign interp = SAMPLE_BITS'(acc_ff >>> F);
   assign q      = acc_ff >>> GAIN_FRAC;

   always_comb begin
      priority if (q > SAT_HI) begin
         y_sat = SAMPLE_BITS'(SAT_HI);
      end else if (q < SAT_LO) begin
         y_sat = SAMPLE_BITS'(SAT_LO);
      end else begin
         y_sat = SAMPLE_BITS'(q);
      end
   end

   // ---- write position ----
   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (cmd.out_load) begin
         if (wp_ff == LAST_IDX) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff <= MAX_DELAY_RESET;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         mac_en_ff    <= 1'b0;
         mac_clr_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            max_delay_ff <= csr_max_delay;
         end
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         mac_en_ff  <= cmd.mac_en;
         mac_clr_ff <= cmd.mac_clr;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lim_ff  <= lim_in;
      prod_ff <= prod_in;
      if (cmd.load_item) begin
         x_ff   <= req_sample_in;
         ffd_ff <= req_ff_delay;
         fbd_ff <= req_fb_delay;
         ga_ff  <= req_direct_gain;
         gb_ff  <= req_ff_gain;
         gc_ff  <= req_fb_gain;
      end
      if (cmd.clamp_load) begin
         dly_ff <= dly_in;
      end
      if (cmd.addr_load) begin
         i_ff    <= idx;
         j_ff    <= idx_nxt;
         frac_ff <= (F + 1)'(pos & FRAC_MASK);
      end
      if (cmd.rd_en) begin
         rd_live_ff <= cmd.tap_sel ? out_live : in_live;
         rd_tap_ff  <= cmd.tap_sel;
      end
      if (mac_en_ff) begin
         acc_ff <= mac_clr_ff ? ACW'(prod_ff) : (acc_ff + ACW'(prod_ff));
      end
      if (cmd.save_en) begin
         if (cmd.tap_sel) begin
            dy_ff <= interp;
         end else begin
            dx_ff <= interp;
         end
      end
      if (cmd.out_load) begin
         rsp_ff <= y_sat;
      end
   end

   assign rsp_sample_out = rsp_ff;

endmodule

/* rtl/dual_delay_comb_filter.sv */
// Dual-delay comb filter, top level: y = a*x[n] + b*x[n-dff] + c*y[n-dfb].
// Depends on ddcf_pkg, ddcf_ctrl, ddcf_datapath and ddcf_ram.
//
// Each transfer on the req_ channel carries one sample, a feedforward and a
// feedback delay (unsigned, DELAY_FRAC_BITS fraction bits) and three Q4.12
// gains; each produces exactly one saturated sample on the rsp_ channel.
// Both delays are clamped to [1, max_delay] (max_delay is further limited
// to RING_DEPTH-1, and zero acts as one) and read from their history ring
// by linear interpolation between neighbors, wrapping at the ring edge.
// The sequencer takes one item at a time: req_stall stays high from the
// transfer until the result is loaded into the rsp_ output register, after
// the feedforward tap, the feedback tap and the gain products; a stalled
// result holds the sequencer in its final step. The sequence comes from one
// shared multiplier (two interpolation products per tap plus three gain
// products) and from one read port per ring, each tap needing two reads.
// The rings need no clearing pass: the write position only counts up from
// reset, so an entry not yet written is recognized from the position and a
// wrapped flag and reads as zero. Write max_delay through csr_ only while
// no item is in flight, unchecked by the block; csr_ready is always high.

module dual_delay_comb_filter #(
   parameter int RING_DEPTH      = 65536,
   parameter int SAMPLE_BITS     = 24,
   parameter int DELAY_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // item channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  logic [ddcf_pkg::DELAY_BITS-1:0]       req_ff_delay,
   input  logic [ddcf_pkg::DELAY_BITS-1:0]       req_fb_delay,
   input  logic signed [ddcf_pkg::GAIN_BITS-1:0] req_direct_gain,
   input  logic signed [ddcf_pkg::GAIN_BITS-1:0] req_ff_gain,
   input  logic signed [ddcf_pkg::GAIN_BITS-1:0] req_fb_gain,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddcf_pkg::CFG_BITS-1:0]         csr_max_delay
);
   import ddcf_pkg::*;

   ddcf_cmd_type cmd;
   logic         csr_write;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequencer: one item at a time, output register frees req_ early
   ddcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // rings, tap addressing, multiply-accumulate, saturation
   ddcf_datapath #(
      .RING_DEPTH      (RING_DEPTH),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_sample_in   (req_sample_in),
      .req_ff_delay    (req_ff_delay),
      .req_fb_delay    (req_fb_delay),
      .req_direct_gain (req_direct_gain),
      .req_ff_gain     (req_ff_gain),
      .req_fb_gain     (req_fb_gain),
      .csr_write       (csr_write),
      .csr_max_delay   (csr_max_delay),
      .rsp_sample_out  (rsp_sample_out)
   );

endmodule

/* test/testbench.sv */
// Testbench for dual_delay_comb_filter: random and directed samples with a self-checking scoreboard.
// Depends on ddcf_pkg and the dual_delay_comb_filter RTL.
`timescale 1ns / 100ps

typedef struct packed {
   logic signed [23:0]                          sample;
   logic [ddcf_pkg::DELAY_BITS-1:0]             ff_delay;
   logic [ddcf_pkg::DELAY_BITS-1:0]             fb_delay;
   logic signed [ddcf_pkg::GAIN_BITS-1:0]       direct_gain;
   logic signed [ddcf_pkg::GAIN_BITS-1:0]       ff_gain;
   logic signed [ddcf_pkg::GAIN_BITS-1:0]       fb_gain;
} filter_req_type;

// Comb filter predictor and store of expected output samples
class comb_scoreboard;
   localparam int RING = 65536;
   localparam int FRAC = 8;

   logic signed [23:0]            dry_ring [RING];   // past input samples
   logic signed [23:0]            wet_ring [RING];   // past output samples
   logic [15:0]                   wr_pos;
   logic [ddcf_pkg::CFG_BITS-1:0] max_delay;
   logic signed [23:0]            expected_q [$];
   int                            errors;
   int                            checked;

   function new();
      foreach (dry_ring[k]) begin
         dry_ring[k] = '0;
         wet_ring[k] = '0;
      end
      wr_pos    = '0;
      max_delay = ddcf_pkg::MAX_DELAY_RESET;
      errors    = 0;
      checked   = 0;
   endfunction

   function void set_max_delay(logic [ddcf_pkg::CFG_BITS-1:0] value);
      max_delay = value;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // interpolated read of one history ring at a clamped fractional delay
   function longint read_tap(bit from_output, logic [23:0] dly_in);
      longint bound, d, pos, frac, i, j, lo, hi;
      bound = max_delay;
      if (bound > RING - 1) bound = RING - 1;
      if (bound < 1) bound = 1;
      bound = bound << FRAC;
      d = dly_in;
      if (d > bound) d = bound;
      if (d < (1 << FRAC)) d = 1 << FRAC;
      pos  = ((longint'(wr_pos) << FRAC) + (longint'(RING) << FRAC) - d)
             % (longint'(RING) << FRAC);
      i    = pos >> FRAC;
      frac = pos & ((1 << FRAC) - 1);
      j    = (i + 1) % RING;
      if (from_output) begin
         lo = wet_ring[i];
         hi = wet_ring[j];
      end else begin
         lo = dry_ring[i];
         hi = dry_ring[j];
      end
      return (lo * ((1 << FRAC) - frac) + hi * frac) >>> FRAC;
   endfunction

   function void note_request(filter_req_type r);
      longint x, dx, dy, a, b, c, y;
      dry_ring[wr_pos] = r.sample;
      x  = $signed(r.sample);
      a  = $signed(r.direct_gain);
      b  = $signed(r.ff_gain);
      c  = $signed(r.fb_gain);
      dx = read_tap(1'b0, r.ff_delay);
      dy = read_tap(1'b1, r.fb_delay);
      y  = (a * x + b * dx + c * dy) >>> ddcf_pkg::GAIN_FRAC;
      if (y > 64'sd8388607) y = 64'sd8388607;
      else if (y < -64'sd8388608) y = -64'sd8388608;
      wet_ring[wr_pos] = y[23:0];
      wr_pos = wr_pos + 16'd1;
      expected_q.push_back(y[23:0]);
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      errors++;
   endtask

   task check_result(logic [23:0] got);
      logic signed [23:0] want;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("output sample %0d with nothing expected", $signed(got)));
      end else begin
         want = expected_q.pop_front();
         if (got !== want)
            report_mismatch($sformatf("sample %0d: sample_out %0d, expected %0d",
                                      checked, $signed(got), want));
      end
      checked++;
   endtask
endclass

module testbench;

   localparam int SAMPLE_BITS     = 24;
   localparam int RING_DEPTH      = 65536;
   localparam int DELAY_FRAC_BITS = 8;
   localparam int PHASE_ITEMS     = 150;
   localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
   localparam int DRAIN_CYCLES    = 40;     // settle time after the last result
   localparam int CYCLE_LIMIT     = 500000;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [SAMPLE_BITS-1:0]         req_sample_in = '0;
   logic [ddcf_pkg::DELAY_BITS-1:0]       req_ff_delay = '0;
   logic [ddcf_pkg::DELAY_BITS-1:0]       req_fb_delay = '0;
   logic signed [ddcf_pkg::GAIN_BITS-1:0] req_direct_gain = '0;
   logic signed [ddcf_pkg::GAIN_BITS-1:0] req_ff_gain = '0;
   logic signed [ddcf_pkg::GAIN_BITS-1:0] req_fb_gain = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0]         rsp_sample_out;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [ddcf_pkg::CFG_BITS-1:0]         csr_max_delay = '0;

   comb_scoreboard board;

   bit quiet = 1'b0;        // no idling on either side while set
   int hold_asked = 0;      // bumped by the sender side to request a long hold-off
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   dual_delay_comb_filter #(
      .RING_DEPTH      (RING_DEPTH),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_in   (req_sample_in),
      .req_ff_delay    (req_ff_delay),
      .req_fb_delay    (req_fb_delay),
      .req_direct_gain (req_direct_gain),
      .req_ff_gain     (req_ff_gain),
      .req_fb_gain     (req_fb_gain),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_delay   (csr_max_delay)
   );

   initial forever #6 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** dual_delay_comb_filter: FAILED **");
      $finish;
   end

   // Result side: random stalls, quiet stretches, and a long hold-off on request.
   // The hold is counted here so the sender keeps offering items meanwhile.
   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 35);
      end
   end

   // Every result transfer is checked against the oldest expected sample
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_sample_out);
   end

   // Offer one item and hold it until the transfer; valid stays high on return
   task send_request(filter_req_type r);
      req_valid       <= 1'b1;
      req_sample_in   <= r.sample;
      req_ff_delay    <= r.ff_delay;
      req_fb_delay    <= r.fb_delay;
      req_direct_gain <= r.direct_gain;
      req_ff_gain     <= r.ff_gain;
      req_fb_gain     <= r.fb_gain;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
   endtask

   task send_fields(int s, int ff, int fb, int a, int b, int c);
      filter_req_type r;
      r.sample      = s[23:0];
      r.ff_delay    = ff[23:0];
      r.fb_delay    = fb[23:0];
      r.direct_gain = a[15:0];
      r.ff_gain     = b[15:0];
      r.fb_gain     = c[15:0];
      send_request(r);
   endtask

   // Sender gap of random length so pauses land on every step of the sequencer
   task idle_gap();
      if (!quiet && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected sample has come back
   task drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task write_max_delay(logic [ddcf_pkg::CFG_BITS-1:0] value);
      csr_valid     <= 1'b1;
      csr_max_delay <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_max_delay(value);
   endtask

   // Mostly short delays inside written history, some near the clamp, some anywhere
   function automatic logic [23:0] random_delay();
      int unsigned pick;
      int          v;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         v = $urandom_range(0, 40 * 256);
      end else if (pick < 85) begin
         v = (int'(board.max_delay) << DELAY_FRAC_BITS) + $urandom_range(0, 1023) - 512;
         if (v < 0) v = $urandom_range(0, 255);
         if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      end else begin
         v = $urandom;
      end
      return v[23:0];
   endfunction

   function automatic logic [15:0] random_gain(int span);
      int v;
      if ($urandom_range(0, 3) == 0) v = $urandom;
      else v = $urandom_range(0, 2 * span) - span;
      return v[15:0];
   endfunction

   function automatic filter_req_type random_request();
      filter_req_type r;
      int unsigned    pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) r.sample = 24'h7FFFFF;
      else if (pick < 10) r.sample = 24'h800000;
      else r.sample = 24'($urandom);
      r.ff_delay    = random_delay();
      r.fb_delay    = random_delay();
      r.direct_gain = random_gain(8192);
      r.ff_gain     = random_gain(8192);
      r.fb_gain     = random_gain(3500);   // keep the feedback loop mostly tame
      return r;
   endfunction

   initial begin
      logic [ddcf_pkg::CFG_BITS-1:0] setting;
      int                            phase;
      int                            k;

      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset clamp of 48000 samples.
      // Second item sits at write position 1 with a 1.5 delay: both taps
      // interpolate between the last ring entry and entry zero.
      send_fields(8388607, 0, 0, 32767, 0, 0);                  // saturate high, delays below one
      idle_gap();
      send_fields(-8388608, 384, 384, 32767, 4096, 4096);       // ring-edge interpolation
      idle_gap();
      send_fields(-8388608, 255, 1, -32768, -32768, -32768);    // fraction-only delays
      idle_gap();
      send_fields(0, 24'hFFFFFF, 24'hFFFFFF, 0, 32767, 32767);  // both taps clamped high
      idle_gap();
      send_fields(1234567, 48000 << 8, (48000 << 8) + 1, 4096, 4096, 4096);
      idle_gap();
      send_fields(-1, 24'h0001FF, 24'h0002FF, 4096, -4096, 2048);
      idle_gap();
      send_fields(8388607, 256, 512, 4096, 4096, -4096);
      idle_gap();
      send_fields(-4096, 24'h000280, 24'h000180, 0, 0, 0);      // all gains zero
      idle_gap();
      send_fields(24'h555555, 24'h00AAAA, 24'h555555, 16'h5555, 16'hAAAA, 16'h5555);
      idle_gap();
      send_fields(24'hAAAAAA, 24'hAAAAAA, 24'h0055AA, 16'hAAAA, 16'h5555, 16'hAAAA);
      idle_gap();
      send_fields(100, 256, 256, 4096, 0, 32767);               // strong feedback
      idle_gap();
      send_fields(100, 24'h010080, 24'h000780, 32767, 32767, 32767);
      idle_gap();
      send_fields(-8388608, 256, 256, 4096, 4096, 4096);
      idle_gap();
      send_fields(8388607, 24'h000300, 24'h000200, 1, 1, 1);     // tiny gains, floor
      idle_gap();
      send_fields(-5, 24'h000101, 24'h0001FF, 1, -1, 1);         // negative floor
      idle_gap();

      // Random phases, each under its own clamp. A clamp of zero acts as one.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       setting = 16'd0;
            1:       setting = 16'd65535;
            2:       setting = 16'd1;
            3:       setting = 16'($urandom_range(2, 64));
            4:       setting = 16'($urandom_range(1000, 65534));
            default: setting = ddcf_pkg::MAX_DELAY_RESET;
         endcase
         drain_results();
         write_max_delay(setting);
         if (phase == 1)
            hold_asked++;        // receiver holds off while items keep coming
         for (k = 0; k < PHASE_ITEMS; k++) begin
            quiet = (phase == 3 && k < 100);
            if (phase == 2 && k == 75)
               drain_results();  // sender pause until the pipe is empty
            send_request(random_request());
            idle_gap();
         end
         quiet = 1'b0;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("** dual_delay_comb_filter: PASSED **");
      else
         $display("** dual_delay_comb_filter: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ddcf_pkg.sv
rtl/ddcf_ram.sv
rtl/ddcf_ctrl.sv
rtl/ddcf_datapath.sv
rtl/dual_delay_comb_filter.sv
test/testbench.sv
